// ===== hdl/skvt_pkg.sv =====
package skvt_pkg;

   // Fixed field widths of the command and response transactions.
   localparam int unsigned CmdW    = 2;
   localparam int unsigned KeyW    = 64;
   localparam int unsigned LenW    = 4;
   localparam int unsigned ValW    = 64;
   localparam int unsigned StatusW = 3;
   localparam int unsigned CountW  = 7;

   typedef enum logic [CmdW-1:0] {
      CMD_GET    = 2'd0,
      CMD_PUT    = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [StatusW-1:0] {
      ST_OK         = 3'd0,
      ST_NOT_FOUND  = 3'd1,
      ST_FULL       = 3'd2,
      ST_BAD_KEY    = 3'd3,
      ST_VALUE_LONG = 3'd4
   } status_type;

   // Control broadcast from the sequencer to every cell.
   typedef struct packed {
      logic cmp_en;   // latch compare flags against the incoming key
      logic ins;      // insert: shift up from the insertion point
      logic upd;      // overwrite the value of the matching cell
      logic del;      // delete: shift down from the matching cell
   } ctl_type;

   // Mask that keeps the first n bytes of a 64-bit word, counting from the top.
   function automatic logic [63:0] top_mask(input logic [LenW-1:0] n);
      logic [6:0] sh;
      logic [63:0] m;
      sh = 7'd64 - {n[3:0], 3'b000};
      if (n == '0) begin
         m = '0;
      end else if (n >= 4'd8) begin
         m = '1;
      end else begin
         m = ~64'd0 << sh;
      end
      return m;
   endfunction

endpackage

// ===== hdl/skvt_req_if.sv =====
interface skvt_req_if;
   logic                            valid;
   logic                            ready;
   logic [skvt_pkg::CmdW-1:0]       command;
   logic [skvt_pkg::KeyW-1:0]       key;
   logic [skvt_pkg::LenW-1:0]       key_len;
   logic [skvt_pkg::ValW-1:0]       value;
   logic [skvt_pkg::LenW-1:0]       value_len;
   logic [skvt_pkg::LenW-1:0]       get_capacity;

   modport source (output valid, command, key, key_len, value, value_len, get_capacity,
                   input ready);
   modport sink (input valid, command, key, key_len, value, value_len, get_capacity,
                 output ready);
endinterface

// ===== hdl/skvt_rsp_if.sv =====
interface skvt_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [skvt_pkg::StatusW-1:0]    status;
   logic [skvt_pkg::ValW-1:0]       value_out;
   logic [skvt_pkg::LenW-1:0]       value_len_out;
   logic [skvt_pkg::CountW-1:0]     entry_count;

   modport source (output valid, status, value_out, value_len_out, entry_count,
                   input ready);
   modport sink (input valid, status, value_out, value_len_out, entry_count,
                 output ready);
endinterface

// ===== hdl/skvt_cell.sv =====
module skvt_cell #(
   parameter int unsigned INDEX  = 0,
   parameter int unsigned KEY_W  = 64,
   parameter int unsigned VAL_W  = 64,
   parameter int unsigned CNT_W  = 7
) (
   input  logic                          clock,
   input  skvt_pkg::ctl_type             ctl,
   input  logic [CNT_W-1:0]              count,
   // Broadcast key and value of the transaction in flight.
   input  logic [KEY_W-1:0]              new_key,
   input  logic [skvt_pkg::LenW-1:0]     new_key_len,
   input  logic [VAL_W-1:0]              new_val,
   input  logic [skvt_pkg::LenW-1:0]     new_val_len,
   // Entry and order flag of the lower neighbor.
   input  logic                          left_lt,
   input  logic [KEY_W-1:0]              left_key,
   input  logic [skvt_pkg::LenW-1:0]     left_key_len,
   input  logic [VAL_W-1:0]              left_val,
   input  logic [skvt_pkg::LenW-1:0]     left_val_len,
   // Entry of the upper neighbor.
   input  logic [KEY_W-1:0]              right_key,
   input  logic [skvt_pkg::LenW-1:0]     right_key_len,
   input  logic [VAL_W-1:0]              right_val,
   input  logic [skvt_pkg::LenW-1:0]     right_val_len,
   // This cell's entry and compare flags.
   output logic [KEY_W-1:0]              key,
   output logic [skvt_pkg::LenW-1:0]     key_len,
   output logic [VAL_W-1:0]              val,
   output logic [skvt_pkg::LenW-1:0]     val_len,
   output logic                          lt,
   output logic                          eq
);

   logic [KEY_W-1:0]          key_ff, key_in;
   logic [skvt_pkg::LenW-1:0] key_len_ff, key_len_in;
   logic [VAL_W-1:0]          val_ff, val_in;
   logic [skvt_pkg::LenW-1:0] val_len_ff, val_len_in;
   logic                      lt_ff, lt_in;
   logic                      eq_ff, eq_in;

   logic                      live;
   logic [skvt_pkg::LenW-1:0] min_len;
   logic [KEY_W-1:0]          cmp_mask;
   logic [KEY_W-1:0]          pa;
   logic [KEY_W-1:0]          pb;

   // The cell holds a live entry when it sits below the entry count.
   assign live = count > CNT_W'(INDEX);

   // Compare the stored key with the incoming one over their common prefix.
   always_comb begin
      logic [63:0] full_mask;
      min_len   = (key_len_ff < new_key_len) ? key_len_ff : new_key_len;
      full_mask = skvt_pkg::top_mask(min_len);
      cmp_mask  = full_mask[63 -: KEY_W];
      pa        = key_ff & cmp_mask;
      pb        = new_key & cmp_mask;
      lt_in     = lt_ff;
      eq_in     = eq_ff;
      if (ctl.cmp_en) begin
         lt_in = live && ((pa < pb) || ((pa == pb) && (key_len_ff < new_key_len)));
         eq_in = live && (pa == pb) && (key_len_ff == new_key_len);
      end
   end

   // Entry update: take the new entry, a neighbor's entry, or a new value.
   always_comb begin
      key_in     = key_ff;
      key_len_in = key_len_ff;
      val_in     = val_ff;
      val_len_in = val_len_ff;
      if (ctl.ins && !lt_ff) begin
         if (left_lt) begin
            key_in     = new_key;
            key_len_in = new_key_len;
            val_in     = new_val;
            val_len_in = new_val_len;
         end else begin
            key_in     = left_key;
            key_len_in = left_key_len;
            val_in     = left_val;
            val_len_in = left_val_len;
         end
      end else if (ctl.upd && eq_ff) begin
         val_in     = new_val;
         val_len_in = new_val_len;
      end else if (ctl.del && !lt_ff) begin
         key_in     = right_key;
         key_len_in = right_key_len;
         val_in     = right_val;
         val_len_in = right_val_len;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      key_len_ff <= key_len_in;
      val_ff     <= val_in;
      val_len_ff <= val_len_in;
      lt_ff      <= lt_in;
      eq_ff      <= eq_in;
   end

   assign key     = key_ff;
   assign key_len = key_len_ff;
   assign val     = val_ff;
   assign val_len = val_len_ff;
   assign lt      = lt_ff;
   assign eq      = eq_ff;

endmodule

// ===== hdl/sorted_key_value_table_top.sv =====
// Sorted key/value table built as a row of entry cells kept in ascending key order.
// Command transactions arrive on req_ch (get, put, delete with key, value and
// lengths); each produces exactly one response transaction on rsp_ch carrying
// status, the value read by a get, its length and the live entry count.
// Keys compare byte by byte from the first byte; a key that is a prefix of a
// longer key sorts first. A new key is inserted by shifting the upper cells up
// one place; a delete shifts them down.
// A command accepted at an edge is compared against every cell at that edge; the
// cells shift or update and the response is registered when the command fires.
// One command is in flight at a time, so no new command is accepted until the
// response to the last one is registered; the compare-then-shift step sets this.
// If the response is not taken, the pending command waits in its register and
// no further command is accepted until the response slot frees up.
// Reset empties the table (entry count zero) and drops any pending response;
// the cell contents are not cleared and are never read before being written.
module sorted_key_value_table_top #(
   parameter int unsigned TABLE_DEPTH = 64,
   parameter int unsigned KEY_BYTES   = 8,
   parameter int unsigned VALUE_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   skvt_req_if.sink    req_ch,
   skvt_rsp_if.source  rsp_ch
);

   localparam int unsigned KeyW = 8 * KEY_BYTES;
   localparam int unsigned ValW = 8 * VALUE_BYTES;
   localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned LenW = skvt_pkg::LenW;

   // Request holding registers.
   logic                      busy_ff, busy_in;
   skvt_pkg::cmd_type         cmd_ff, cmd_in;
   logic [KeyW-1:0]           key_ff, key_in;
   logic [LenW-1:0]           key_len_ff, key_len_in;
   logic [ValW-1:0]           val_ff, val_in;
   logic [LenW-1:0]           val_len_ff, val_len_in;
   logic [LenW-1:0]           cap_ff, cap_in;
   logic [CntW-1:0]           count_ff, count_in;

   // Response registers.
   logic                      rsp_valid_ff, rsp_valid_in;
   skvt_pkg::status_type      status_ff, status_in;
   logic [ValW-1:0]           vout_ff, vout_in;
   logic [LenW-1:0]           vlen_out_ff, vlen_out_in;

   logic                      accept;
   logic                      fire;
   logic [63:0]               req_key_m;
   logic [63:0]               req_val_m;
   logic [KeyW-1:0]           bcast_key;
   logic [LenW-1:0]           bcast_key_len;
   skvt_pkg::ctl_type         ctl;

   logic [KeyW-1:0]           cell_key     [TABLE_DEPTH];
   logic [LenW-1:0]           cell_key_len [TABLE_DEPTH];
   logic [ValW-1:0]           cell_val     [TABLE_DEPTH];
   logic [LenW-1:0]           cell_val_len [TABLE_DEPTH];
   logic                      cell_lt      [TABLE_DEPTH];
   logic                      cell_eq      [TABLE_DEPTH];

   logic                      hit;
   logic [ValW-1:0]           sel_val;
   logic [LenW-1:0]           sel_val_len;
   logic                      key_bad;
   logic                      table_full;

   assign accept        = req_ch.valid && req_ch.ready;
   assign req_ch.ready  = !busy_ff;
   assign fire          = busy_ff && (!rsp_valid_ff || rsp_ch.ready);

   // Incoming key and value with unused bytes cleared.
   assign req_key_m     = req_ch.key & skvt_pkg::top_mask(req_ch.key_len);
   assign req_val_m     = req_ch.value & skvt_pkg::top_mask(req_ch.value_len);

   // The cells compare against the live request; afterwards they see the held one.
   assign bcast_key     = busy_ff ? key_ff : req_key_m[63 -: KeyW];
   assign bcast_key_len = busy_ff ? key_len_ff : req_ch.key_len;

   // Read out the matching cell; at most one live cell matches.
   always_comb begin
      hit         = 1'b0;
      sel_val     = '0;
      sel_val_len = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         hit         = hit | cell_eq[i];
         sel_val     = sel_val | (cell_eq[i] ? cell_val[i] : '0);
         sel_val_len = sel_val_len | (cell_eq[i] ? cell_val_len[i] : '0);
      end
   end

   assign key_bad    = (key_len_ff == '0) || (key_len_ff > LenW'(KEY_BYTES));
   assign table_full = count_ff == CntW'(TABLE_DEPTH);

   // Command decode: choose the cell operation and the response.
   always_comb begin
      ctl         = '0;
      ctl.cmp_en  = accept;
      count_in    = count_ff;
      status_in   = status_ff;
      vout_in     = vout_ff;
      vlen_out_in = vlen_out_ff;
      if (fire) begin
         status_in   = skvt_pkg::ST_OK;
         vout_in     = '0;
         vlen_out_in = '0;
         if (cmd_ff == skvt_pkg::CMD_NONE) begin
            status_in = skvt_pkg::ST_OK;
         end else if (key_bad) begin
            status_in = skvt_pkg::ST_BAD_KEY;
         end else begin
            unique case (cmd_ff)
               skvt_pkg::CMD_GET: begin
                  if (!hit) begin
                     status_in = skvt_pkg::ST_NOT_FOUND;
                  end else begin
                     vlen_out_in = sel_val_len;
                     if (cap_ff < sel_val_len) begin
                        status_in = skvt_pkg::ST_VALUE_LONG;
                     end else begin
                        vout_in = sel_val;
                     end
                  end
               end
               skvt_pkg::CMD_PUT: begin
                  if (val_len_ff > LenW'(VALUE_BYTES)) begin
                     status_in = skvt_pkg::ST_VALUE_LONG;
                  end else if (hit) begin
                     ctl.upd = 1'b1;
                  end else if (table_full) begin
                     status_in = skvt_pkg::ST_FULL;
                  end else begin
                     ctl.ins  = 1'b1;
                     count_in = count_ff + CntW'(1);
                  end
               end
               skvt_pkg::CMD_DELETE: begin
                  if (!hit) begin
                     status_in = skvt_pkg::ST_NOT_FOUND;
                  end else begin
                     ctl.del  = 1'b1;
                     count_in = count_ff - CntW'(1);
                  end
               end
               default: begin
                  status_in = skvt_pkg::ST_OK;
               end
            endcase
         end
      end
   end

   // Request capture and transaction handshake control.
   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      key_len_in   = key_len_ff;
      val_in       = val_ff;
      val_len_in   = val_len_ff;
      cap_in       = cap_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (fire) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
      end
      if (accept) begin
         busy_in    = 1'b1;
         cmd_in     = skvt_pkg::cmd_type'(req_ch.command);
         key_in     = req_key_m[63 -: KeyW];
         key_len_in = req_ch.key_len;
         val_in     = req_val_m[63 -: ValW];
         val_len_in = req_ch.value_len;
         cap_in     = req_ch.get_capacity;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      key_len_ff  <= key_len_in;
      val_ff      <= val_in;
      val_len_ff  <= val_len_in;
      cap_ff      <= cap_in;
      status_ff   <= status_in;
      vout_ff     <= vout_in;
      vlen_out_ff <= vlen_out_in;
   end

   // Row of entry cells, each linked to both neighbors.
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      localparam int unsigned Lo = (g == 0) ? 0 : g - 1;
      localparam int unsigned Hi = (g == TABLE_DEPTH - 1) ? g : g + 1;

      skvt_cell #(
         .INDEX (g),
         .KEY_W (KeyW),
         .VAL_W (ValW),
         .CNT_W (CntW)
      ) u_cell (
         .clock         (clock),
         .ctl           (ctl),
         .count         (count_ff),
         .new_key       (bcast_key),
         .new_key_len   (bcast_key_len),
         .new_val       (val_ff),
         .new_val_len   (val_len_ff),
         .left_lt       ((g == 0) ? 1'b1 : cell_lt[Lo]),
         .left_key      (cell_key[Lo]),
         .left_key_len  (cell_key_len[Lo]),
         .left_val      (cell_val[Lo]),
         .left_val_len  (cell_val_len[Lo]),
         .right_key     (cell_key[Hi]),
         .right_key_len (cell_key_len[Hi]),
         .right_val     (cell_val[Hi]),
         .right_val_len (cell_val_len[Hi]),
         .key           (cell_key[g]),
         .key_len       (cell_key_len[g]),
         .val           (cell_val[g]),
         .val_len       (cell_val_len[g]),
         .lt            (cell_lt[g]),
         .eq            (cell_eq[g])
      );
   end

   // Response transaction outputs.
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = status_ff;
   assign rsp_ch.value_out     = skvt_pkg::ValW'(vout_ff) << (skvt_pkg::ValW - ValW);
   assign rsp_ch.value_len_out = vlen_out_ff;
   assign rsp_ch.entry_count   = skvt_pkg::CountW'(count_ff);

endmodule
